// File: design/shbi_pkg.sv
package shbi_pkg;

	localparam int unsigned HashW    = 32;
	localparam int unsigned BucketW  = 31;
	localparam int unsigned LogW     = 5;
	localparam int unsigned ByteW    = 8;
	localparam int unsigned QDepth   = 4;
	localparam int unsigned QPtrW    = $clog2(QDepth);
	localparam int unsigned StepCntW = $clog2(HashW);
	localparam logic [LogW-1:0] LogReset = LogW'(3);
	localparam logic [StepCntW-1:0] LastStep = StepCntW'(HashW - 1);

	// one finished name waiting for its modulo
	typedef struct packed {
		logic [HashW-1:0]   hash;
		logic [BucketW-1:0] modulus;
	} qent_t;

	// largest prime below 2**lg (1 for lg 0, 2 for lg 1)
	function automatic logic [BucketW-1:0] prime_below(input logic [LogW-1:0] lg);
		logic [BucketW-1:0] p;
		unique case (lg)
			5'd0:  p = 31'd1;
			5'd1:  p = 31'd2;
			5'd2:  p = 31'd3;
			5'd3:  p = 31'd7;
			5'd4:  p = 31'd13;
			5'd5:  p = 31'd31;
			5'd6:  p = 31'd61;
			5'd7:  p = 31'd127;
			5'd8:  p = 31'd251;
			5'd9:  p = 31'd509;
			5'd10: p = 31'd1021;
			5'd11: p = 31'd2039;
			5'd12: p = 31'd4093;
			5'd13: p = 31'd8191;
			5'd14: p = 31'd16381;
			5'd15: p = 31'd32749;
			5'd16: p = 31'd65521;
			5'd17: p = 31'd131071;
			5'd18: p = 31'd262139;
			5'd19: p = 31'd524287;
			5'd20: p = 31'd1048573;
			5'd21: p = 31'd2097143;
			5'd22: p = 31'd4194301;
			5'd23: p = 31'd8388593;
			5'd24: p = 31'd16777213;
			5'd25: p = 31'd33554393;
			5'd26: p = 31'd67108859;
			5'd27: p = 31'd134217689;
			5'd28: p = 31'd268435399;
			5'd29: p = 31'd536870909;
			5'd30: p = 31'd1073741789;
			default: p = 31'd2147483647;
		endcase
		return p;
	endfunction

	function automatic logic [HashW-1:0] mix_byte(input logic [HashW-1:0] h_in,
	                                              input logic [ByteW-1:0] b);
		logic [HashW-1:0] h;
		h = h_in + HashW'(b);
		h = h + (h << 10);
		h = h ^ (h >> 6);
		return h;
	endfunction

	function automatic logic [HashW-1:0] finish_hash(input logic [HashW-1:0] h_in);
		logic [HashW-1:0] h;
		h = h_in + (h_in << 3);
		h = h ^ (h >> 11);
		h = h + (h << 15);
		return h;
	endfunction

endpackage

// File: design/shbi_front.sv
module shbi_front
	import shbi_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [ByteW-1:0] s_tdata,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [LogW-1:0]  cfg_data,
	input  logic             q_full,
	output logic             q_push,
	output qent_t            q_wdata
);

	logic [HashW-1:0] run_hash_q;
	logic [LogW-1:0]  log2_q;
	logic             take;

	assign cfg_ready = 1'b1;
	assign s_tready  = !q_full;
	assign take      = s_tvalid && s_tready;
	assign q_push    = take && (s_tdata == '0);

	assign q_wdata.hash    = finish_hash(run_hash_q);
	assign q_wdata.modulus = prime_below(log2_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_hash_q <= '0;
			log2_q     <= LogReset;
		end else begin
			if (cfg_valid && cfg_ready) begin
				log2_q <= cfg_data;
			end
			if (take) begin
				if (s_tdata == '0) begin
					run_hash_q <= '0;
				end else begin
					run_hash_q <= mix_byte(run_hash_q, s_tdata);
				end
			end
		end
	end

endmodule

// File: design/shbi_fifo.sv
module shbi_fifo
	import shbi_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  qent_t wdata,
	output logic  full,
	input  logic  pop,
	output logic  nonempty,
	output qent_t rdata
);

	qent_t              mem_q [QDepth];
	logic [QPtrW-1:0]   wr_ptr_q;
	logic [QPtrW-1:0]   rd_ptr_q;
	logic [QPtrW:0]     count_q;

	assign full     = (count_q == (QPtrW+1)'(QDepth));
	assign nonempty = (count_q != '0);
	assign rdata    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: design/shbi_mod.sv
module shbi_mod
	import shbi_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_nonempty,
	input  qent_t                      q_rdata,
	output logic                       q_pop,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [HashW+BucketW:0]     m_tdata
);

	logic                busy_q;
	logic [StepCntW-1:0] cnt_q;
	logic [HashW-1:0]    shift_q;
	logic [HashW-1:0]    hold_q;
	logic [BucketW-1:0]  mod_q;
	logic [HashW-1:0]    rem_q;
	logic                out_valid_q;
	logic [HashW-1:0]    out_hash_q;
	logic [BucketW-1:0]  out_bucket_q;

	logic [HashW-1:0]    rem_sh;
	logic [HashW-1:0]    rem_nx;
	logic                last;
	logic                out_free;
	logic                step;

	// restoring remainder, one hash bit per cycle, msb first; the last step waits while an untaken result is held
	assign rem_sh   = {rem_q[HashW-2:0], shift_q[HashW-1]};
	assign rem_nx   = (rem_sh >= {1'b0, mod_q}) ? rem_sh - {1'b0, mod_q} : rem_sh;
	assign last     = (cnt_q == LastStep);
	assign out_free = !out_valid_q || m_tready;
	assign step     = busy_q && (!last || out_free);
	assign q_pop    = !busy_q && q_nonempty;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_bucket_q, out_hash_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (step) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q      <= 1'b0;
					out_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			shift_q <= q_rdata.hash;
			hold_q  <= q_rdata.hash;
			mod_q   <= q_rdata.modulus;
			rem_q   <= '0;
		end else if (step) begin
			shift_q <= {shift_q[HashW-2:0], 1'b0};
			rem_q   <= rem_nx;
			if (last) begin
				out_hash_q   <= hold_q;
				out_bucket_q <= rem_nx[BucketW-1:0];
			end
		end
	end

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !busy_q)
		else $error("queue popped while modulo unit busy");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rem_q < {1'b0, mod_q}))
		else $error("partial remainder not below modulus");

	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(step && last) |=> (!busy_q && out_valid_q))
		else $error("last step did not post a result");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |-> !(step && last))
		else $error("pending result overwritten");

endmodule

// File: design/string_hash_bucket_index_core.sv
// channel   dir   signals                      payload (lsb up)
// s_*       in    s_tvalid s_tready s_tdata    [7:0] name_byte
// m_*       out   m_tvalid m_tready m_tdata    [31:0] hash_value, [62:32] bucket_index, [63] zero
// cfg_*     in    cfg_valid cfg_ready cfg_data [4:0] table_size_log2
//
// Name bytes are taken one a cycle; s_tready drops only when the 4-entry name queue is full.
// Each zero byte queues one finished hash; the back end works through each name in a
// bit-serial modulo unit, one hash bit per step, and pops no new name until it is done.
// The ending byte's hash passes the queue and all modulo steps before m_tvalid rises.
// Reset (arst_n low, async) clears the running hash, queue and result; table_size_log2 -> 3.
// A stalled m_tready holds the last modulo step; bytes keep flowing until the queue fills.
module string_hash_bucket_index_core
	import shbi_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// request in: name_byte [7:0]
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [ByteW-1:0]       s_tdata,
	// request out: hash_value [31:0], bucket_index [62:32]
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [HashW+BucketW:0] m_tdata,
	// register write: table_size_log2 [4:0]
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [LogW-1:0]        cfg_data
);

	logic  q_full;
	logic  q_push;
	logic  q_pop;
	logic  q_nonempty;
	qent_t q_wdata;
	qent_t q_rdata;

	// front: mixes bytes, finalizes on zero byte, looks up the prime
	shbi_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_wdata   (q_wdata)
	);

	// queue of finished hashes with their modulus
	shbi_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wdata    (q_wdata),
		.full     (q_full),
		.pop      (q_pop),
		.nonempty (q_nonempty),
		.rdata    (q_rdata)
	);

	// back: serial modulo and output register
	shbi_mod u_mod (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_rdata    (q_rdata),
		.q_pop      (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule

// File: sim/shbi_checker.sv
module shbi_checker
	import shbi_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [ByteW-1:0]       s_tdata,    // name_byte [7:0]
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [HashW+BucketW:0] m_tdata,    // hash_value [31:0], bucket_index [62:32], zero [63]
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [LogW-1:0]        cfg_data,   // table_size_log2 [4:0]
	output int                     errors,
	output int                     outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [ByteW-1:0] NameEnd = '0;

	// largest prime below each power of two (1 and 2 for log2 0 and 1), index = log2 of table size
	localparam logic [31:0][BucketW-1:0] BucketPrime = {
		31'd2147483647, 31'd1073741789, 31'd536870909, 31'd268435399,
		31'd134217689,  31'd67108859,   31'd33554393,  31'd16777213,
		31'd8388593,    31'd4194301,    31'd2097143,   31'd1048573,
		31'd524287,     31'd262139,     31'd131071,    31'd65521,
		31'd32749,      31'd16381,      31'd8191,      31'd4093,
		31'd2039,       31'd1021,       31'd509,       31'd251,
		31'd127,        31'd61,         31'd31,        31'd13,
		31'd7,          31'd3,          31'd2,         31'd1
	};

	typedef struct packed {
		logic [HashW-1:0]   hash;
		logic [BucketW-1:0] bucket;
	} hash_bucket_t;

	hash_bucket_t     names_done[$];
	logic [HashW-1:0] run_hash;
	logic [LogW-1:0]  tbl_log2;

	function automatic logic [HashW-1:0] fold_char(input logic [HashW-1:0] acc,
	                                               input logic [ByteW-1:0] c);
		logic [HashW-1:0] t;
		t = acc + {{(HashW-ByteW){1'b0}}, c};
		t = t + (t << 10);
		t = t ^ (t >> 6);
		return t;
	endfunction

	function automatic logic [HashW-1:0] seal_hash(input logic [HashW-1:0] acc);
		logic [HashW-1:0] t;
		t = acc + (acc << 3);
		t = t ^ (t >> 11);
		t = t + (t << 15);
		return t;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		hash_bucket_t     want;
		hash_bucket_t     got;
		logic             pad;
		logic [HashW-1:0] sealed;
		int               bad;
		bad = 0;
		if (!arst_n) begin
			names_done.delete();
			run_hash = '0;
			tbl_log2 = LogReset;
			errors <= 0;
			outstanding <= 0;
		end else begin
			// results leave before this edge's byte can add a new name
			if (m_tvalid && m_tready) begin
				got.hash   = m_tdata[HashW-1:0];
				got.bucket = m_tdata[HashW +: BucketW];
				pad        = m_tdata[HashW+BucketW];
				if (names_done.size() == 0) begin
					$error("result with no name pending: hash_value %h bucket_index %0d",
					       got.hash, got.bucket);
					bad++;
				end else begin
					want = names_done.pop_front();
					if (got.hash !== want.hash) begin
						$error("hash_value: expected %h, got %h", want.hash, got.hash);
						bad++;
					end
					if (got.bucket !== want.bucket) begin
						$error("bucket_index: expected %0d, got %0d", want.bucket, got.bucket);
						bad++;
					end
					if (pad !== 1'b0) begin
						$error("pad bit: expected 0, got %b", pad);
						bad++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tdata != NameEnd) begin
					run_hash = fold_char(run_hash, s_tdata);
				end else begin
					// modulus is the one in force on the ending byte
					sealed      = seal_hash(run_hash);
					want.hash   = sealed;
					want.bucket = BucketW'(sealed % {1'b0, BucketPrime[tbl_log2]});
					names_done.push_back(want);
					run_hash = '0;
				end
			end
			if (cfg_valid && cfg_ready) begin
				tbl_log2 = cfg_data;
			end
			errors <= errors + bad;
			outstanding <= names_done.size();
		end
	end

endmodule

// File: sim/tb_string_hash_bucket_index_core.sv
module tb_string_hash_bucket_index_core;
	import shbi_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// covers the result time with an empty queue; a little slack on top
	localparam int TailCycles    = 48;
	// long enough for the 4-deep name queue to fill and push back on s_tready
	localparam int SqueezeCycles = 400;
	// slowest run is roughly the requests times (longest gap + longest stall + a modulo
	// pass) plus the register-write pauses; several times that
	localparam int CycleLimit    = 400000;
	localparam logic [ByteW-1:0] NameEnd = '0;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [ByteW-1:0]       s_tdata   = '0;    // name_byte [7:0]
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [HashW+BucketW:0] m_tdata;           // hash_value [31:0], bucket_index [62:32], zero [63]
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [LogW-1:0]        cfg_data  = '0;    // table_size_log2 [4:0]

	int errors;
	int outstanding;
	int sent    = 0;    // name bytes accepted so far
	int cycles  = 0;
	bit steady  = 1'b0; // sender offers back to back when set
	bit squeeze = 1'b0; // asks the sink for one long hold-off

	always #10 clk = ~clk;

	string_hash_bucket_index_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	shbi_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.errors      (errors),
		.outstanding (outstanding)
	);

	// mostly no gap or a short one, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// tvalid stays high from one request to the next unless a gap is taken,
	// so it is never dropped and raised in the same step
	task automatic push_byte(input logic [ByteW-1:0] b);
		int gap;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	task automatic push_name(input string txt);
		for (int i = 0; i < txt.len(); i++) push_byte(txt[i]);
		push_byte(NameEnd);
	endtask

	// short names mostly, some long; an unfinished one stays open for the next phase
	task automatic push_random_name(input bit finish);
		int len;
		len = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 6) : $urandom_range(7, 40);
		repeat (len) push_byte(8'($urandom_range(1, 255)));
		if (finish) push_byte(NameEnd);
	endtask

	// wait for every pending name to come out, then for the back end to go quiet;
	// the extra cycles cover bytes that produce no result
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (TailCycles) @(posedge clk);
	endtask

	task automatic write_log2(input logic [LogW-1:0] lg);
		settle();
		cfg_valid <= 1'b1;
		cfg_data  <= lg;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("FAILURE");
			$finish;
		end
	end

	// sink: random stalls and ready stretches, plus one long hold-off on request
	initial begin
		int stall;
		int open_left;
		open_left = 0;
		@(posedge arst_n);
		forever begin
			if (squeeze) begin
				squeeze = 1'b0;
				m_tready <= 1'b0;
				repeat (SqueezeCycles) @(posedge clk);
			end else if (open_left > 0) begin
				open_left--;
				m_tready <= 1'b1;
				@(posedge clk);
			end else begin
				stall = pick_gap();
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				// now and then a long stretch with no stall at all
				open_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
				                                        : $urandom_range(1, 8);
			end
		end
	end

	// source: directed names, then random phases at several table sizes
	initial begin
		int target;
		logic [LogW-1:0] lg;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// table size at reset (log2 3, prime 7)
		push_byte(NameEnd);                        // empty name: hash 0, bucket 0
		push_byte(8'hFF);
		push_byte(NameEnd);
		push_byte(8'h01);
		push_byte(8'h80);
		push_byte(NameEnd);
		push_byte(8'h55);
		push_byte(8'hAA);
		push_byte(NameEnd);
		push_name("key");

		// smallest table: modulus 1, bucket always 0
		write_log2(5'd0);
		push_byte(8'h7F);
		push_byte(8'hFE);
		push_byte(NameEnd);

		// largest table: modulus 2^31-1
		write_log2(5'd31);
		push_name("value");

		// register written mid-name: the ending byte sees the new modulus
		push_byte(8'h41);
		push_byte(8'h42);
		write_log2(5'd1);
		push_byte(8'h43);
		push_byte(NameEnd);

		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				0: lg = 5'd2;
				1: lg = 5'd16;
				2: lg = 5'd31;
				3: lg = 5'd0;
				default: lg = 5'($urandom_range(0, 31));
			endcase
			write_log2(lg);
			steady = (ph % 4 == 2);
			if (ph == 5) begin
				// hold the sink and keep offering empty names until the queue backs up
				squeeze = 1'b1;
				repeat (16) push_byte(NameEnd);
			end
			target = sent + 32;
			while (sent < target) push_random_name(1'b1);
			if ($urandom_range(0, 2) == 0) push_random_name(1'b0);
		end
		steady = 1'b0;

		settle();
		if (errors == 0 && outstanding == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
